// File: design/lcg_xor_block_shuffle_decrypt_core_assert.svh
// Assertion macros for the decrypt core RTL, included by lxbsd_step.
`ifndef LCG_XOR_BLOCK_SHUFFLE_DECRYPT_CORE_ASSERT_SVH
`define LCG_XOR_BLOCK_SHUFFLE_DECRYPT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that cons holds in the same cycle as ante.
`define LXBSD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define LXBSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LXBSD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define LXBSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: design/lxbsd_pkg.sv
package lxbsd_pkg;

    localparam int WORDS_PER_BLOCK_DEF = 28;

    localparam logic [31:0] LCG_MUL = 32'h41C6_4E6D;
    localparam logic [31:0] LCG_INC = 32'h0000_6073;

    localparam int          ORDER_LSB   = 13;
    localparam int          ORDER_W     = 5;
    localparam logic [4:0]  ORDER_COUNT = 5'd24;
    localparam logic [3:0]  DIGIT_BASE  = 4'hA;

    // Each hex digit (most significant first) names the destination block
    // of source block 0..3, offset by DIGIT_BASE.
    localparam logic [15:0] ORDER_TABLE [24] = '{
        16'hABCD, 16'hABDC, 16'hACBD, 16'hACDB, 16'hADBC, 16'hADCB,
        16'hBACD, 16'hBADC, 16'hBCAD, 16'hBCDA, 16'hBDAC, 16'hBDCA,
        16'hCABD, 16'hCADB, 16'hCBAD, 16'hCBDA, 16'hCDAB, 16'hCDBA,
        16'hDABC, 16'hDACB, 16'hDBAC, 16'hDBCA, 16'hDCAB, 16'hDCBA
    };

    typedef struct packed {
        logic        first_word;
        logic [31:0] record_key;
        logic [15:0] cipher_word;
    } in_item_t;

    typedef struct packed {
        logic [15:0] plain_word;
        logic [1:0]  dest_block;
        logic [4:0]  dest_index;
        logic        last_word;
    } out_item_t;

    // Reduce key bits 17..13 modulo the number of block orders.
    function automatic logic [ORDER_W-1:0] order_of_key(input logic [31:0] key);
        logic [ORDER_W-1:0] raw;
        begin
            raw = key[ORDER_LSB +: ORDER_W];
            order_of_key = (raw >= ORDER_COUNT) ? raw - ORDER_COUNT : raw;
        end
    endfunction

    function automatic logic [1:0] dest_of(input logic [ORDER_W-1:0] sel,
                                           input logic [1:0] src);
        logic [15:0] code;
        logic [3:0]  digit;
        logic [3:0]  diff;
        begin
            code = (sel < ORDER_COUNT) ? ORDER_TABLE[sel] : ORDER_TABLE[0];
            case (src)
                2'd0:    digit = code[15:12];
                2'd1:    digit = code[11:8];
                2'd2:    digit = code[7:4];
                default: digit = code[3:0];
            endcase
            diff    = digit - DIGIT_BASE;
            dest_of = diff[1:0];
        end
    endfunction

endpackage

// File: design/lxbsd_in_reg.sv
module lxbsd_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cipher_valid,
    output logic                cipher_stall,
    input  lxbsd_pkg::in_item_t cipher_item,
    input  logic                drain,
    output logic                item_valid,
    output lxbsd_pkg::in_item_t item
);
    import lxbsd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Take a new transaction when empty or when the held one moves on.
    assign cipher_stall = valid_reg && !drain;
    assign valid_next   = cipher_stall ? valid_reg : cipher_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cipher_valid && !cipher_stall)
        begin
            item_reg <= cipher_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: design/lxbsd_step.sv
module lxbsd_step #(
    parameter int WORDS_PER_BLOCK = lxbsd_pkg::WORDS_PER_BLOCK_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  lxbsd_pkg::in_item_t  item,
    output lxbsd_pkg::out_item_t res
);
    import lxbsd_pkg::*;

    `include "lcg_xor_block_shuffle_decrypt_core_assert.svh"

    localparam int             POS_W    = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WORDS_PER_BLOCK - 1);

    logic [31:0]        lcg_reg;
    logic [31:0]        lcg_next;
    logic [1:0]         block_reg;
    logic [1:0]         block_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [ORDER_W-1:0] order_reg;
    logic [ORDER_W-1:0] order_next;

    logic [31:0]        lcg_base;
    logic [1:0]         cur_block;
    logic [POS_W-1:0]   cur_pos;
    logic               cur_last;
    logic [POS_W+4:0]   pos_ext;

    always_comb
    begin
        // A first word restarts the record with the new key.
        lcg_base   = item.first_word ? item.record_key : lcg_reg;
        order_next = item.first_word ? order_of_key(item.record_key) : order_reg;
        cur_block  = item.first_word ? 2'd0 : block_reg;
        cur_pos    = item.first_word ? '0 : pos_reg;

        lcg_next = lcg_base * LCG_MUL + LCG_INC;
        cur_last = (cur_block == 2'd3) && (cur_pos == LAST_POS);

        if (cur_pos == LAST_POS)
        begin
            block_next = cur_block + 2'd1;
            pos_next   = '0;
        end
        else
        begin
            block_next = cur_block;
            pos_next   = cur_pos + POS_W'(1);
        end

        pos_ext = {5'd0, cur_pos};

        res.plain_word = item.cipher_word ^ lcg_next[31:16];
        res.dest_block = dest_of(order_next, cur_block);
        res.dest_index = pos_ext[4:0];
        res.last_word  = cur_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg   <= '0;
            block_reg <= '0;
            pos_reg   <= '0;
            order_reg <= '0;
        end
        else if (advance)
        begin
            lcg_reg   <= lcg_next;
            block_reg <= block_next;
            pos_reg   <= pos_next;
            order_reg <= order_next;
        end
    end

    `LXBSD_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1, pos_reg <= LAST_POS,
        "word position past block end")
    `LXBSD_ASSERT_IMP(a_order_range, clk, rst_n, 1'b1, order_reg < ORDER_COUNT,
        "block order out of range")
    `LXBSD_ASSERT_NEXT(a_wrap, clk, rst_n, advance && res.last_word,
        block_reg == 2'd0 && pos_reg == '0, "record did not wrap after last word")
    `LXBSD_ASSERT_NEXT(a_key_load, clk, rst_n, advance && item.first_word,
        order_reg == order_of_key($past(item.record_key)), "block order not loaded from key")

endmodule

// File: design/lxbsd_out_reg.sv
module lxbsd_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  lxbsd_pkg::out_item_t res,
    output logic                 ready,
    output logic                 plain_valid,
    input  logic                 plain_stall,
    output lxbsd_pkg::out_item_t plain_item
);
    import lxbsd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // Free when empty or when the held transaction leaves this cycle.
    assign ready      = !valid_reg || !plain_stall;
    assign valid_next = ready ? load : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && ready)
        begin
            item_reg <= res;
        end
    end

    assign plain_valid = valid_reg;
    assign plain_item  = item_reg;

endmodule

// File: design/lcg_xor_block_shuffle_decrypt_core.sv
// Decrypts records of four blocks of WORDS_PER_BLOCK 16-bit words, one word per
// transaction, and reports for each word its destination block and position after
// unshuffling; a set first_word loads the key and restarts the record. The core
// takes one word per clock unless the result side stalls; results pass the input
// register, then the result register. The 32-bit constant multiply-add of the LCG
// step, which feeds back into its own state, sets the cycle time.
module lcg_xor_block_shuffle_decrypt_core #(
    parameter int WORDS_PER_BLOCK = lxbsd_pkg::WORDS_PER_BLOCK_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cipher_valid,
    output logic                 cipher_stall,
    input  lxbsd_pkg::in_item_t  cipher_item,
    output logic                 plain_valid,
    input  logic                 plain_stall,
    output lxbsd_pkg::out_item_t plain_item
);
    import lxbsd_pkg::*;

    logic      item_valid;
    in_item_t  item;
    out_item_t res;
    logic      ready;
    logic      advance;

    assign advance = item_valid && ready;

    lxbsd_in_reg u_in_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cipher_valid (cipher_valid),
        .cipher_stall (cipher_stall),
        .cipher_item  (cipher_item),
        .drain        (ready),
        .item_valid   (item_valid),
        .item         (item)
    );

    lxbsd_step #(
        .WORDS_PER_BLOCK (WORDS_PER_BLOCK)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .res     (res)
    );

    lxbsd_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .res         (res),
        .ready       (ready),
        .plain_valid (plain_valid),
        .plain_stall (plain_stall),
        .plain_item  (plain_item)
    );

endmodule

// File: dv/tb_lcg_xor_block_shuffle_decrypt_core.sv
module tb_lcg_xor_block_shuffle_decrypt_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lxbsd_pkg::*;

    localparam int WPB          = WORDS_PER_BLOCK_DEF;
    localparam int RECORD_WORDS = 4 * WPB;
    localparam int RANDOM_WORDS = 1800;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 250;
    localparam int HOLD_AFTER   = 400;

    // One row of the directed table: the word to send, and when pinned is set,
    // the result written out by hand instead of taken from the predictor.
    typedef struct packed {
        in_item_t  word;
        logic      pinned;
        out_item_t pinned_out;
    } dir_row_t;

    localparam logic [24:0] PREDICT = 25'd0;

    localparam dir_row_t DIRECTED [13] = '{
        // before any key: LCG 0 steps to 0x6073, upper half zero, identity order
        {1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'hFFFF, 2'd0, 5'd0, 1'b0},
        {1'b0, 32'h0000_0000, 16'h0000, PREDICT},
        // key zero restarts mid-record with a zero keystream word
        {1'b1, 32'h0000_0000, 16'h1234, 1'b1, 16'h1234, 2'd0, 5'd0, 1'b0},
        {1'b0, 32'hFFFF_FFFF, 16'hFFFF, PREDICT},
        {1'b1, 32'hFFFF_FFFF, 16'h0000, PREDICT},
        {1'b0, 32'h0000_0000, 16'h8000, PREDICT},
        // order field 23, 24 (wraps to 0), 31 (wraps to 7), 1
        {1'b1, 32'h0002_E000, 16'hFFFF, PREDICT},
        {1'b1, 32'h0003_0000, 16'h0001, PREDICT},
        {1'b1, 32'h0003_E000, 16'h7FFF, PREDICT},
        {1'b1, 32'h0000_2000, 16'hFFFE, PREDICT},
        {1'b1, 32'h0000_0000, 16'hAAAA, 1'b1, 16'hAAAA, 2'd0, 5'd0, 1'b0},
        {1'b1, 32'h0000_0000, 16'h5555, 1'b1, 16'h5555, 2'd0, 5'd0, 1'b0},
        {1'b1, 32'h8000_0001, 16'h8001, PREDICT}
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cipher_valid = 1'b0;
    logic      cipher_stall;
    in_item_t  cipher_item = '0;
    logic      plain_valid;
    logic      plain_stall = 1'b0;
    out_item_t plain_item;

    // predictor state
    logic [31:0] keystream = '0;
    int          word_pos = 0;
    logic [4:0]  order_sel = '0;

    out_item_t plain_due_q[$];

    int cycle_count = 0;
    int mismatches = 0;
    int words_sent = 0;
    int records_opened = 0;
    int results_seen = 0;
    int record_ends = 0;
    int input_held = 0;
    int burst_left = 0;

    lcg_xor_block_shuffle_decrypt_core #(
        .WORDS_PER_BLOCK(WPB)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cipher_valid(cipher_valid),
        .cipher_stall(cipher_stall),
        .cipher_item (cipher_item),
        .plain_valid (plain_valid),
        .plain_stall (plain_stall),
        .plain_item  (plain_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_item_t decrypt_word(input in_item_t w);
        out_item_t   r;
        int          src;
        logic [15:0] code;
        if (w.first_word)
        begin
            keystream = w.record_key;
            order_sel = 5'(w.record_key[ORDER_LSB +: ORDER_W] % ORDER_COUNT);
            word_pos  = 0;
        end
        if (word_pos >= RECORD_WORDS)
            word_pos = 0;
        keystream    = keystream * LCG_MUL + LCG_INC;
        src          = word_pos / WPB;
        code         = ORDER_TABLE[order_sel];
        r.plain_word = w.cipher_word ^ keystream[31:16];
        r.dest_block = 2'(code[4 * (3 - src) +: 4] - DIGIT_BASE);
        r.dest_index = 5'(word_pos % WPB);
        r.last_word  = (word_pos == RECORD_WORDS - 1);
        word_pos     = r.last_word ? 0 : word_pos + 1;
        return r;
    endfunction

    // Offer one word in bursts of random length; hold it until the core takes it.
    task automatic send_word(input in_item_t w, input logic pinned, input out_item_t want);
        int        gap;
        out_item_t predicted;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                cipher_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cipher_valid <= 1'b1;
        cipher_item  <= w;
        do
            @(posedge clk);
        while (cipher_stall);
        predicted = decrypt_word(w);
        plain_due_q.push_back(pinned ? want : predicted);
        words_sent++;
        if (w.first_word)
            records_opened++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && cipher_valid && cipher_stall)
            input_held++;
        if (rst_n && plain_valid && !plain_stall)
        begin
            results_seen++;
            if (plain_item.last_word === 1'b1)
                record_ends++;
            if (plain_due_q.size() == 0)
            begin
                $error("result transaction with nothing expected: %h", plain_item);
                mismatches++;
            end
            else
            begin
                want = plain_due_q.pop_front();
                if (plain_item.plain_word !== want.plain_word)
                begin
                    $error("plain_word: expected %h, got %h",
                           want.plain_word, plain_item.plain_word);
                    mismatches++;
                end
                if (plain_item.dest_block !== want.dest_block)
                begin
                    $error("dest_block: expected %0d, got %0d",
                           want.dest_block, plain_item.dest_block);
                    mismatches++;
                end
                if (plain_item.dest_index !== want.dest_index)
                begin
                    $error("dest_index: expected %0d, got %0d",
                           want.dest_index, plain_item.dest_index);
                    mismatches++;
                end
                if (plain_item.last_word !== want.last_word)
                begin
                    $error("last_word: expected %0d, got %0d",
                           want.last_word, plain_item.last_word);
                    mismatches++;
                end
            end
        end
    end

    // Result side stall pattern, with one long hold-off once traffic is flowing.
    initial
    begin
        int  stall_mode;
        int  run_left;
        int  hold_left;
        bit  did_hold;
        stall_mode = 0;
        run_left   = 0;
        hold_left  = 0;
        did_hold   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                plain_stall <= 1'b1;
            end
            else if (!did_hold && results_seen >= HOLD_AFTER)
            begin
                did_hold  = 1'b1;
                hold_left = LONG_HOLD - 1;
                plain_stall <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    run_left   = $urandom_range(20, 120);
                end
                run_left--;
                case (stall_mode)
                    0:       plain_stall <= 1'b0;
                    1:       plain_stall <= ($urandom_range(0, 3) == 0);
                    2:       plain_stall <= ($urandom_range(0, 1) == 0);
                    default: plain_stall <= (run_left % 3 != 0);
                endcase
            end
        end
    end

    initial
    begin
        in_item_t w;
        int       kind;
        int       n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_word(DIRECTED[i].word, DIRECTED[i].pinned, DIRECTED[i].pinned_out);

        // Mostly whole records; some cut short by a new key, some running on past
        // the final word without one.
        while (words_sent < RANDOM_WORDS + $size(DIRECTED))
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
                n = RECORD_WORDS;
            else if (kind < 85)
                n = $urandom_range(1, 60);
            else
                n = $urandom_range(1, 150);
            for (int k = 0; k < n; k++)
            begin
                w.first_word  = (kind < 85) && (k == 0);
                w.record_key  = $urandom();
                w.cipher_word = 16'($urandom());
                send_word(w, 1'b0, '0);
            end
        end
        cipher_valid <= 1'b0;

        while (plain_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words in %0d keyed records; %0d results, %0d record ends.",
                 words_sent, records_opened, results_seen, record_ends);
        $display("Core held off input for %0d cycles.", input_held);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
